/* rtl/single_wire_humidity_sensor_reader_top_assert.svh */
// Assertion macros shared by the sensor reader modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SWHSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWHSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds on every cycle out of reset.
`define SWHSR_ASSERT_ALW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

/* rtl/swhsr_pkg.sv */
package swhsr_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_START_LOW_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_TICKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIT_THRESHOLD   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS   = 2'd3;

  localparam logic [15:0] START_LOW_RESET = 16'd20000;
  localparam logic [7:0]  RELEASE_RESET   = 8'd20;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd40;
  localparam logic [7:0]  TIMEOUT_RESET   = 8'd255;

  localparam logic [5:0] NUM_BITS = 6'd40;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_ticks;
    logic [7:0]  bit_threshold;
    logic [7:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic cmd;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       drive_enable;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_frac;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_frac;
  } out_item_t;

endpackage

/* rtl/swhsr_cfg.sv */
module swhsr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swhsr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swhsr_pkg::CfgDataW-1:0] cfg_data,
  output swhsr_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks <= swhsr_pkg::START_LOW_RESET;
      cfg.release_ticks   <= swhsr_pkg::RELEASE_RESET;
      cfg.bit_threshold   <= swhsr_pkg::THRESHOLD_RESET;
      cfg.timeout_ticks   <= swhsr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        swhsr_pkg::CFG_START_LOW_TICKS: cfg.start_low_ticks <= cfg_data;
        swhsr_pkg::CFG_RELEASE_TICKS:   cfg.release_ticks   <= cfg_data[7:0];
        swhsr_pkg::CFG_BIT_THRESHOLD:   cfg.bit_threshold   <= cfg_data[7:0];
        swhsr_pkg::CFG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/swhsr_core.sv */
module swhsr_core (
  input  logic                 clk,
  input  logic                 rst,
  input  swhsr_pkg::cfg_t      cfg,
  input  logic                 fire,
  input  swhsr_pkg::in_item_t  in_item,
  output swhsr_pkg::out_item_t res
);

  `include "single_wire_humidity_sensor_reader_top_assert.svh"

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START_LOW = 3'd1,
    PH_RELEASE   = 3'd2,
    PH_RESP_LOW  = 3'd3,
    PH_RESP_HIGH = 3'd4,
    PH_BIT_GAP   = 3'd5,
    PH_BIT_HIGH  = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [5:0]  bit_index, bit_index_next;
  logic [39:0] shift_data, shift_data_next;

  logic       timed;
  logic       finished;
  logic       bit_val;
  logic [7:0] sum;
  logic       show_bytes;
  logic [15:0] timeout_ext;

  assign timeout_ext = {8'd0, cfg.timeout_ticks};

  // checksum over the four data bytes of the updated shift word
  assign sum = shift_data_next[39:32] + shift_data_next[31:24]
             + shift_data_next[23:16] + shift_data_next[15:8];

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_data_next = shift_data;
    timed           = 1'b0;
    finished        = 1'b0;
    bit_val         = 1'b0;
    case (phase)
      PH_START_LOW: begin
        if (tick_count >= cfg.start_low_ticks) begin
          phase_next      = PH_RELEASE;
          tick_count_next = 16'd1;
        end else begin
          tick_count_next = tick_count + 16'd1;
        end
      end
      PH_RELEASE: begin
        if (tick_count >= {8'd0, cfg.release_ticks}) begin
          phase_next      = PH_RESP_LOW;
          tick_count_next = 16'd0;
        end else begin
          tick_count_next = tick_count + 16'd1;
        end
      end
      PH_RESP_LOW: begin
        if (!in_item.line_level) begin
          tick_count_next = tick_count + 16'd1;
        end else begin
          phase_next      = PH_RESP_HIGH;
          tick_count_next = 16'd1;
        end
        timed = tick_count_next >= timeout_ext;
      end
      PH_RESP_HIGH: begin
        if (in_item.line_level) begin
          tick_count_next = tick_count + 16'd1;
        end else begin
          phase_next      = PH_BIT_GAP;
          tick_count_next = 16'd1;
        end
        timed = tick_count_next >= timeout_ext;
      end
      PH_BIT_GAP: begin
        if (!in_item.line_level) begin
          tick_count_next = tick_count + 16'd1;
        end else begin
          phase_next      = PH_BIT_HIGH;
          tick_count_next = 16'd1;
        end
        timed = tick_count_next >= timeout_ext;
      end
      PH_BIT_HIGH: begin
        if (in_item.line_level) begin
          tick_count_next = tick_count + 16'd1;
          timed           = tick_count_next >= timeout_ext;
        end else begin
          // falling edge: decide the bit from the pulse length
          bit_val         = tick_count > {8'd0, cfg.bit_threshold};
          shift_data_next = {shift_data[38:0], bit_val};
          bit_index_next  = bit_index + 6'd1;
          if (bit_index_next >= swhsr_pkg::NUM_BITS) begin
            finished = 1'b1;
          end else begin
            phase_next      = PH_BIT_GAP;
            tick_count_next = 16'd1;
            timed           = tick_count_next >= timeout_ext;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (in_item.cmd) begin
          phase_next      = PH_START_LOW;
          tick_count_next = 16'd1;
          bit_index_next  = 6'd0;
          shift_data_next = 40'd0;
        end
      end
    endcase

    res          = '0;
    if (timed || finished) begin
      phase_next      = PH_IDLE;
      tick_count_next = 16'd0;
      res.done_res    = 1'b1;
      if (timed) begin
        res.status = swhsr_pkg::STATUS_TIMEOUT;
      end else if (sum == shift_data_next[7:0]) begin
        res.status = swhsr_pkg::STATUS_OK;
      end else begin
        res.status = swhsr_pkg::STATUS_CHECKSUM;
      end
    end
    show_bytes = finished && !timed;
    if (show_bytes) begin
      res.humidity_whole    = shift_data_next[39:32];
      res.humidity_frac     = shift_data_next[31:24];
      res.temperature_whole = shift_data_next[23:16];
      res.temperature_frac  = shift_data_next[15:8];
    end
    res.drive_low    = (phase_next == PH_START_LOW);
    res.drive_enable = (phase_next == PH_START_LOW) || (phase_next == PH_RELEASE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 16'd0;
      bit_index  <= 6'd0;
      shift_data <= 40'd0;
    end else if (fire) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_data <= shift_data_next;
    end
  end

  `SWHSR_ASSERT_ALW(a_idle_count_clear, (phase != PH_IDLE) || (tick_count == 16'd0),
    "idle phase with nonzero tick count")
  `SWHSR_ASSERT_ALW(a_bit_index_range, bit_index <= swhsr_pkg::NUM_BITS,
    "bit index beyond frame length")
  `SWHSR_ASSERT_IMP(a_data_done_full_frame,
    res.done_res && (res.status != swhsr_pkg::STATUS_TIMEOUT),
    (phase == PH_BIT_HIGH) && (bit_index_next == swhsr_pkg::NUM_BITS),
    "data result without a full frame")

endmodule

/* rtl/swhsr_skid.sv */
module swhsr_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swhsr_pkg::out_item_t res,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swhsr_pkg::out_item_t out_item
);

  `include "single_wire_humidity_sensor_reader_top_assert.svh"

  logic                 skid_valid;
  swhsr_pkg::out_item_t skid_item;
  logic                 in_fire;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      // output slot frees up: skid first, else the fresh result
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (in_fire) begin
        out_item <= res;
      end
    end else if (in_fire) begin
      skid_item <= res;
    end
  end

  `SWHSR_ASSERT_ALW(a_skid_implies_out, !skid_valid || out_valid,
    "skid holds an item while the output register is empty")

endmodule

/* rtl/single_wire_humidity_sensor_reader_top.sv */
// Single-wire humidity/temperature sensor reader.
// Input channel (in_valid/in_stall/in_item): one item per timer tick, holding
//   the start command and the sampled data-wire level. Every item gives
//   exactly one result item.
// Output channel (out_valid/out_stall/out_item): wire drive controls for the
//   following tick, plus done_res, status and the four data bytes on the
//   tick a reading completes.
// Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes, the user
//   writes only while no reading is in flight; the block does not enforce it.
// Each accepted item's result is registered (result register or skid).
// Throughput: 1 item per cycle while in_stall is low; the phase/count/shift
//   update is a single pass of logic between state and result registers.
// Reset: phase idle, counters and shift word cleared, output and skid empty,
//   registers back to their defaults.
// Receiver stall: the result register holds; one further item is caught in
//   the skid stage, after which in_stall rises until the output drains.
module single_wire_humidity_sensor_reader_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  swhsr_pkg::in_item_t            in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output swhsr_pkg::out_item_t           out_item,
  input  logic                           cfg_we,
  input  logic [swhsr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swhsr_pkg::CfgDataW-1:0] cfg_data
);

  swhsr_pkg::cfg_t      cfg;
  swhsr_pkg::out_item_t res;
  logic                 fire;

  // item taken whenever the skid stage is empty
  assign fire = in_valid && !in_stall;

  swhsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // protocol state machine: phase, tick counter, bit index, shift word
  swhsr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .in_item (in_item),
    .res     (res)
  );

  // result register with one-deep skid
  swhsr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
